### rtl/mqtt_fhd_pkg.sv
// ----------------------------------------------------------------------------
// mqtt_fhd_pkg
// Shared types and constants for the mqtt fixed header deframer.
// ----------------------------------------------------------------------------
package mqtt_fhd_pkg;

  localparam int unsigned MaxLengthBytesDefault = 4;

  localparam int unsigned LenW   = 28;
  localparam int unsigned CountW = 3;
  localparam int unsigned TdataOutW = 48;
  localparam int unsigned TuserOutW = 3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } byte_kind_e;

endpackage

### rtl/mqtt_fixed_header_deframer_unit.sv
// ----------------------------------------------------------------------------
// mqtt_fixed_header_deframer_unit
// Tags each byte of an mqtt 3.1.1 stream as header, length or payload byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw stream byte per request. m_axis returns exactly one
//   result per byte: the byte itself, its kind, the current packet type and
//   flags, the remaining length decoded so far, and the length done, last
//   (tlast) and malformed flags.
//   A byte accepted at one edge shows its result at the output register
//   after that edge. Throughput is one byte per cycle while the receiver
//   takes results, set by the single per-byte length/payload tracker update.
//   s_axis_tready stays high while the output register is empty or is being
//   taken in the same cycle; when the receiver stalls, the result holds and
//   the input stalls with it, no byte is lost.
//   A length field running past MAX_LENGTH_BYTES bytes flags the offending
//   byte as malformed and the parser returns to expect a header byte.
//   Reset puts the parser in the expect-header state with an empty output.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer_unit
  import mqtt_fhd_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = MaxLengthBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [7:0] data_byte
  input  logic [7:0]           s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] out_byte, [11:8] packet_type, [15:12] header_flags,
  // [43:16] remaining_length, [44] length_done, [47:45] zero
  output logic [TdataOutW-1:0] m_axis_tdata_o,
  // [1:0] byte_kind, [2] malformed
  output logic [TuserOutW-1:0] m_axis_tuser_o,
  // last
  output logic                 m_axis_tlast_o
);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LenW-1:0]   accum_q, accum_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [3:0]        type_q, type_d;
  logic [3:0]        flags_q, flags_d;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  byte_kind_e        out_kind_q, kind_d;
  logic [3:0]        out_type_q, out_flags_q;
  logic [LenW-1:0]   out_len_q;
  logic              out_done_q, done_d;
  logic              out_last_q, last_d;
  logic              out_bad_q, bad_d;

  logic              in_fire;
  logic [LenW-1:0]   group_shifted;
  logic [LenW-1:0]   accum_sum;
  logic [LenW-1:0]   left_dec;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // 7-bit group placed by length byte index, least significant group first
  always_comb begin
    case (count_q[1:0])
      2'd0:    group_shifted = {21'd0, s_axis_tdata_i[6:0]};
      2'd1:    group_shifted = {14'd0, s_axis_tdata_i[6:0], 7'd0};
      2'd2:    group_shifted = {7'd0, s_axis_tdata_i[6:0], 14'd0};
      default: group_shifted = {s_axis_tdata_i[6:0], 21'd0};
    endcase
  end

  assign accum_sum = accum_q + group_shifted;
  assign left_dec  = left_q - LenW'(1);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    accum_d = accum_q;
    left_d  = left_q;
    type_d  = type_q;
    flags_d = flags_q;
    kind_d  = KIND_HEADER;
    done_d  = 1'b0;
    last_d  = 1'b0;
    bad_d   = 1'b0;
    case (phase_q)
      PH_LENGTH: begin
        kind_d = KIND_LENGTH;
        if (count_q >= CountW'(MAX_LENGTH_BYTES)) begin
          bad_d   = 1'b1;
          phase_d = PH_HEADER;
        end else begin
          accum_d = accum_sum;
          count_d = count_q + CountW'(1);
          if (!s_axis_tdata_i[7]) begin
            done_d = 1'b1;
            if (accum_sum == '0) begin
              last_d  = 1'b1;
              phase_d = PH_HEADER;
            end else begin
              left_d  = accum_sum;
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        kind_d = KIND_PAYLOAD;
        left_d = left_dec;
        if (left_dec == '0) begin
          last_d  = 1'b1;
          phase_d = PH_HEADER;
        end
      end
      default: begin
        type_d  = s_axis_tdata_i[7:4];
        flags_d = s_axis_tdata_i[3:0];
        count_d = '0;
        accum_d = '0;
        left_d  = '0;
        phase_d = PH_LENGTH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      count_q <= '0;
      accum_q <= '0;
      left_q  <= '0;
      type_q  <= '0;
      flags_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      count_q <= count_d;
      accum_q <= accum_d;
      left_q  <= left_d;
      type_q  <= type_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q  <= s_axis_tdata_i;
      out_kind_q  <= kind_d;
      out_type_q  <= type_d;
      out_flags_q <= flags_d;
      out_len_q   <= accum_d;
      out_done_q  <= done_d;
      out_last_q  <= last_d;
      out_bad_q   <= bad_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_done_q, out_len_q, out_flags_q, out_type_q, out_byte_q};
  assign m_axis_tuser_o  = {out_bad_q, out_kind_q};
  assign m_axis_tlast_o  = out_last_q;

  // a malformed byte is always a length byte that neither ends nor completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |->
      (out_kind_q == KIND_LENGTH && !out_last_q && !out_done_q))
    else $error("malformed result with wrong tags");

  // a header byte starts a packet: no length yet, never the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_HEADER) |->
      (!out_last_q && out_len_q == '0 && !out_done_q))
    else $error("header result with length or last set");

  // payload bytes only follow a nonzero remaining length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_PAYLOAD) |-> (out_len_q != '0))
    else $error("payload byte with zero remaining length");

  // an accepted header byte always moves the parser into the length field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_HEADER) |=> (phase_q == PH_LENGTH && count_q == '0))
    else $error("header byte did not enter length phase");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mqtt fixed header deframer. Bytes are streamed
// into s_axis as whole packets (header, remaining length, payload), with some
// overlong length fields mixed in. A cycle-level tagger built into the bench
// predicts the tag of every accepted byte. Each m_axis result is compared
// field by field against the oldest prediction. Both sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_top
  import mqtt_fhd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLenBytes   = MaxLengthBytesDefault;
  localparam int unsigned RandomBytes   = 2000;
  localparam int unsigned IdlePercent   = 14;
  localparam int unsigned DrainCycles   = 4;

  typedef struct packed {
    logic [7:0]      byte_val;
    byte_kind_e      kind;
    logic [3:0]      ptype;
    logic [3:0]      flags;
    logic [LenW-1:0] rem_len;
    logic            len_done;
    logic            last;
    logic            malformed;
  } byte_tag_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata_o;
  logic [TuserOutW-1:0] m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // tagger state
  phase_e            parse_phase  = PH_HEADER;
  logic [CountW-1:0] len_count    = '0;
  logic [LenW-1:0]   len_accum    = '0;
  logic [LenW-1:0]   payload_left = '0;
  logic [3:0]        hdr_type     = '0;
  logic [3:0]        hdr_flags    = '0;

  byte_tag_t   pending_tags[$];
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned overlong_sent = 0;
  int unsigned results_seen = 0;

  mqtt_fixed_header_deframer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(0, 99) >= IdlePercent);
  end

  // advances the tagger by one byte and returns the tag it should get
  function automatic byte_tag_t classify_byte(input logic [7:0] b);
    byte_tag_t t;
    t = '0;
    t.byte_val = b;
    case (parse_phase)
      PH_LENGTH: begin
        t.kind = KIND_LENGTH;
        if (len_count >= MaxLenBytes) begin
          t.malformed = 1'b1;
          parse_phase = PH_HEADER;
        end else begin
          len_accum = len_accum + (LenW'(b[6:0]) << (7 * len_count[1:0]));
          len_count = len_count + 1'b1;
          if (!b[7]) begin
            t.len_done = 1'b1;
            if (len_accum == '0) begin
              t.last = 1'b1;
              parse_phase = PH_HEADER;
            end else begin
              payload_left = len_accum;
              parse_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        t.kind = KIND_PAYLOAD;
        payload_left = payload_left - 1'b1;
        if (payload_left == '0) begin
          t.last = 1'b1;
          parse_phase = PH_HEADER;
        end
      end
      default: begin
        t.kind = KIND_HEADER;
        hdr_type = b[7:4];
        hdr_flags = b[3:0];
        len_count = '0;
        len_accum = '0;
        payload_left = '0;
        parse_phase = PH_LENGTH;
      end
    endcase
    t.ptype = hdr_type;
    t.flags = hdr_flags;
    t.rem_len = len_accum;
    return t;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // results are sampled mid-cycle, the handshake completes at the next edge
  always @(negedge clk_i) begin
    byte_tag_t got;
    byte_tag_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.byte_val  = m_axis_tdata_o[7:0];
      got.ptype     = m_axis_tdata_o[11:8];
      got.flags     = m_axis_tdata_o[15:12];
      got.rem_len   = m_axis_tdata_o[43:16];
      got.len_done  = m_axis_tdata_o[44];
      got.kind      = byte_kind_e'(m_axis_tuser_o[1:0]);
      got.malformed = m_axis_tuser_o[2];
      got.last      = m_axis_tlast_o;
      results_seen++;
      if (pending_tags.size() == 0) begin
        $error("result 0x%0h with no pending request", got.byte_val);
        errors++;
      end else begin
        want = pending_tags.pop_front();
        check_field("out_byte", want.byte_val, got.byte_val);
        check_field("byte_kind", want.kind, got.kind);
        check_field("packet_type", want.ptype, got.ptype);
        check_field("header_flags", want.flags, got.flags);
        check_field("remaining_length", want.rem_len, got.rem_len);
        check_field("length_done", want.len_done, got.len_done);
        check_field("last", want.last, got.last);
        check_field("malformed", want.malformed, got.malformed);
        check_field("tdata pad", '0, m_axis_tdata_o[47:45]);
      end
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_byte(input logic [7:0] b);
    logic taken;
    if (!calm) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      if (taken) pending_tags.push_back(classify_byte(b));
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
  endtask

  // varint with nbytes groups, padded with zero groups if longer than needed
  task automatic send_length(input int unsigned len, input int unsigned nbytes);
    logic [7:0] b;
    for (int unsigned i = 0; i < nbytes; i++) begin
      b[6:0] = 7'((len >> (7 * i)) & 32'h7F);
      b[7] = (i + 1 < nbytes);
      send_byte(b);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_tags.size() != 0);
  endtask

  task automatic test_zero_length();
    send_byte(8'h00);
    send_length(0, 1);
    // non-minimal encoding of zero still ends the packet on the length byte
    send_byte(8'hF0);
    send_length(0, 2);
    packets_sent += 2;
  endtask

  task automatic test_short_packet();
    send_byte(8'h3B);
    send_length(2, 1);
    send_byte(8'h00);
    send_byte(8'hFF);
    packets_sent++;
  endtask

  task automatic test_four_byte_length();
    send_byte(8'h5A);
    send_length(3, MaxLenBytes);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    packets_sent++;
  endtask

  task automatic test_overlong_length();
    // all ones in every group, then a fifth byte without continuation
    send_byte(8'hA5);
    repeat (MaxLenBytes) send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h12);
    repeat (MaxLenBytes) send_byte(8'h80);
    send_byte(8'h80);
    packets_sent += 2;
    overlong_sent += 2;
  endtask

  task automatic test_random_stream();
    int unsigned pick;
    int unsigned len;
    int unsigned nbytes;
    int unsigned pkt;
    int unsigned goal;
    pkt = 0;
    goal = bytes_sent + RandomBytes;
    while (bytes_sent < goal) begin
      calm = (pkt >= 8 && pkt < 20);
      if (pkt == 24) wait_drain();
      pick = $urandom_range(0, 99);
      send_byte(8'($urandom));
      if (pick < 8) begin
        // broken length field: continuation on every allowed byte
        repeat (MaxLenBytes) send_byte({1'b1, 7'($urandom)});
        send_byte(8'($urandom));
        overlong_sent++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 0;
        else if (pick < 75) len = $urandom_range(1, 16);
        else if (pick < 97) len = $urandom_range(17, 200);
        else len = $urandom_range(201, 600);
        nbytes = (len < 128) ? 1 : 2;
        if ($urandom_range(0, 3) == 0) nbytes = $urandom_range(nbytes, MaxLenBytes);
        send_length(len, nbytes);
        repeat (len) send_byte(8'($urandom));
      end
      packets_sent++;
      pkt++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_length();
    test_short_packet();
    test_four_byte_length();
    test_overlong_length();
    wait_drain();
    test_random_stream();
    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_tags.size() != 0) begin
      $error("%0d expected results never arrived", pending_tags.size());
      errors++;
    end
    $display("streamed %0d bytes in %0d packets, %0d with overlong length fields",
             bytes_sent, packets_sent, overlong_sent);
    $display("compared %0d tagged results, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
